@@ rtl/fpr_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the framed packet receiver.
// No dependencies; the interfaces and the receiver import this package.
package fpr_pkg;

    // Default frame store size in bytes
    localparam int FRAME_BYTES_DEF = 256;

    // CRC-16, poly 0x1021, init 0, MSB first
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Header and tail markers
    localparam logic [7:0] HDR_0  = 8'hE1;
    localparam logic [7:0] HDR_1  = 8'hE2;
    localparam logic [7:0] HDR_2  = 8'hE3;
    localparam logic [7:0] HDR_3  = 8'hE4;
    localparam logic [7:0] TAIL_0 = 8'hEA;
    localparam logic [7:0] TAIL_1 = 8'hEB;
    localparam logic [7:0] TAIL_2 = 8'hEC;
    localparam logic [7:0] TAIL_3 = 8'hED;

    // Frame layout
    localparam int HDR_LAST_POS = 3;   // position the final header byte is stored at
    localparam int FIELD_FIRST  = 4;   // sequence byte
    localparam int FIELD_BYTES  = 8;   // bytes 4..11: seq, src, dst, cmd, length
    localparam int CRC_FIRST    = 12;  // first payload byte, CRC follows the payload
    localparam int MIN_OVERHEAD = 18;  // header + fields + length + CRC + tail

    // Input commands
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    // Result kinds
    typedef enum logic {
        KIND_REPORT  = 1'b0,
        KIND_READOUT = 1'b1
    } t_kind;

    // End-of-frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DEST = 2'd1,
        ST_BAD_CRC  = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    // Input request payload
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_fpr_req;

    // Result payload
    typedef struct packed {
        logic        report_kind;
        logic [1:0]  status;
        logic [7:0]  sequence_res;
        logic [15:0] source;
        logic [15:0] destination;
        logic [15:0] command_code;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
    } t_fpr_rsp;

    // One byte through the CRC, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // CRC after the first three header bytes, used when a header restarts capture
    localparam logic [15:0] CRC_HDR_SEED =
        crc16_byte(crc16_byte(crc16_byte(16'h0000, HDR_0), HDR_1), HDR_2);

endpackage

@@ rtl/fpr_if.sv @@
// Valid/ready channel interfaces for the request and result sides.
// Depends on fpr_pkg for the payload structs.
interface fpr_in_if import fpr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_fpr_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fpr_out_if import fpr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_fpr_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/fpr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/framed_packet_receiver.sv @@
// Framed packet receiver: header/tail framing, field capture, CRC-16 check, payload readout.
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; a result that waits
//   unaccepted holds off the next request, whether or not that request makes a result.
// Reset (synchronous, active low) clears framing state, CRC, own address and result valid;
//   the frame store is not cleared and is undefined until written.
module framed_packet_receiver import fpr_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpr_in_if.sink      i_in,
    fpr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    localparam int AW    = $clog2(FRAME_BYTES);
    localparam int WP_W  = $clog2(FRAME_BYTES + 1);
    localparam int SUM_W = (WP_W > 9) ? WP_W : 9;

    // Control and state registers
    logic [15:0]     r_own_addr;
    logic [1:0]      r_hdr, n_hdr;
    logic [1:0]      r_tail, n_tail;
    logic            r_cap, n_cap;
    logic [WP_W-1:0] r_wp, n_wp;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_fld [FIELD_BYTES];
    logic [7:0]      n_fld [FIELD_BYTES];
    logic [7:0]      r_crc_hi, n_crc_hi;
    logic [7:0]      r_crc_lo, n_crc_lo;
    logic            r_out_valid;
    t_fpr_rsp        r_rsp, n_rsp;
    logic            r_rd_ok;

    // Handshake
    logic     ready, in_fire, is_byte, is_read;
    t_fpr_req req;
    logic [7:0] b;

    assign req     = i_in.payload;
    assign b       = req.rx_byte;
    assign ready   = !r_out_valid || o_out.ready;
    assign in_fire = i_in.valid && ready;
    assign is_byte = in_fire && (req.command == CMD_BYTE);
    assign is_read = in_fire && (req.command == CMD_READ);
    assign i_in.ready = ready;

    // Header hunt
    logic restart;
    always_comb begin
        n_hdr   = r_hdr;
        restart = 1'b0;
        if (is_byte) begin
            if (b == HDR_0) begin
                n_hdr = 2'd1;
            end else if (r_hdr == 2'd1 && b == HDR_1) begin
                n_hdr = 2'd2;
            end else if (r_hdr == 2'd2 && b == HDR_2) begin
                n_hdr = 2'd3;
            end else if (r_hdr == 2'd3 && b == HDR_3) begin
                n_hdr   = 2'd0;
                restart = 1'b1;
            end else begin
                n_hdr = 2'd0;
            end
        end
    end

    // State as seen by this byte, after a possible header restart
    logic            cap_e;
    logic [WP_W-1:0] wp_e;
    logic [15:0]     crc_e;
    logic [1:0]      tail_e;
    logic            full, store, drop, covered;
    logic [SUM_W-1:0] wp_s, crc_pos;

    assign cap_e   = restart || r_cap;
    assign wp_e    = restart ? WP_W'(HDR_LAST_POS) : r_wp;
    assign crc_e   = restart ? CRC_HDR_SEED : r_crc;
    assign tail_e  = restart ? 2'd0 : r_tail;
    assign full    = (wp_e == WP_W'(FRAME_BYTES));
    assign store   = is_byte && cap_e && !full;
    assign drop    = is_byte && cap_e && full;
    assign wp_s    = SUM_W'(wp_e);
    // length byte is from this frame whenever the position is past it
    assign crc_pos = SUM_W'(CRC_FIRST) + SUM_W'(r_fld[FIELD_BYTES-1]);
    assign covered = (wp_s < SUM_W'(CRC_FIRST)) || (wp_s < crc_pos);

    // Capture, CRC and tail tracking
    logic tail_done;
    always_comb begin
        n_cap     = r_cap;
        n_wp      = r_wp;
        n_crc     = r_crc;
        n_tail    = r_tail;
        n_crc_hi  = r_crc_hi;
        n_crc_lo  = r_crc_lo;
        tail_done = 1'b0;
        for (int k = 0; k < FIELD_BYTES; k++) begin
            n_fld[k] = r_fld[k];
        end
        if (is_byte) begin
            n_cap  = cap_e;
            n_wp   = wp_e;
            n_crc  = crc_e;
            n_tail = tail_e;
        end
        // overflow drops the frame silently
        if (drop) begin
            n_cap  = 1'b0;
            n_tail = 2'd0;
            n_wp   = '0;
        end
        if (store) begin
            n_wp = wp_e + WP_W'(1);
            if (covered) begin
                n_crc = crc16_byte(crc_e, b);
            end
            for (int k = 0; k < FIELD_BYTES; k++) begin
                if (wp_e == WP_W'(FIELD_FIRST + k)) begin
                    n_fld[k] = b;
                end
            end
            if (wp_s == crc_pos) begin
                n_crc_hi = b;
            end
            if (wp_s == crc_pos + SUM_W'(1)) begin
                n_crc_lo = b;
            end
            if (b == TAIL_0) begin
                n_tail = 2'd1;
            end else if (tail_e == 2'd1 && b == TAIL_1) begin
                n_tail = 2'd2;
            end else if (tail_e == 2'd2 && b == TAIL_2) begin
                n_tail = 2'd3;
            end else if (tail_e == 2'd3 && b == TAIL_3) begin
                n_tail    = 2'd0;
                n_cap     = 1'b0;
                tail_done = 1'b1;
            end else begin
                n_tail = 2'd0;
            end
        end
    end

    // End-of-frame report; bytes not stored in this frame read as zero
    logic [7:0]  fld_m [FIELD_BYTES];
    logic [15:0] dest, rx_crc;
    logic        short_frame;
    always_comb begin
        for (int k = 0; k < FIELD_BYTES; k++) begin
            fld_m[k] = (n_wp > WP_W'(FIELD_FIRST + k)) ? n_fld[k] : 8'h00;
        end
    end
    assign dest        = {fld_m[3], fld_m[4]};
    assign rx_crc      = {n_crc_hi, n_crc_lo};
    assign short_frame = SUM_W'(n_wp) < (SUM_W'(MIN_OVERHEAD) + SUM_W'(fld_m[7]));

    // Readout address
    logic [SUM_W-1:0] rd_pos;
    logic             rd_in_range;
    logic [7:0]       ram_rdata;
    assign rd_pos      = SUM_W'(req.read_index) + SUM_W'(CRC_FIRST);
    assign rd_in_range = rd_pos < SUM_W'(FRAME_BYTES);

    // Next result payload
    always_comb begin
        n_rsp = '0;
        if (req.command == CMD_READ) begin
            n_rsp.report_kind = KIND_READOUT;
        end else begin
            n_rsp.report_kind    = KIND_REPORT;
            n_rsp.sequence_res   = fld_m[0];
            n_rsp.source         = {fld_m[1], fld_m[2]};
            n_rsp.destination    = dest;
            n_rsp.command_code   = {fld_m[5], fld_m[6]};
            n_rsp.payload_length = fld_m[7];
            if (short_frame) begin
                n_rsp.status = ST_SHORT;
            end else if (dest != r_own_addr) begin
                n_rsp.status = ST_BAD_DEST;
            end else if (rx_crc != n_crc) begin
                n_rsp.status = ST_BAD_CRC;
            end else begin
                n_rsp.status = ST_OK;
            end
        end
    end

    // Frame store
    fpr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (wp_e[AW-1:0]),
        .i_wdata (b),
        .i_re    (is_read && rd_in_range),
        .i_raddr (rd_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_hdr       <= '0;
            r_tail      <= '0;
            r_cap       <= 1'b0;
            r_wp        <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_own_addr <= i_cfg_wdata;
            end
            r_hdr  <= n_hdr;
            r_tail <= n_tail;
            r_cap  <= n_cap;
            r_wp   <= n_wp;
            r_crc  <= n_crc;
            if (ready) begin
                r_out_valid <= tail_done || is_read;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < FIELD_BYTES; k++) begin
            r_fld[k] <= n_fld[k];
        end
        r_crc_hi <= n_crc_hi;
        r_crc_lo <= n_crc_lo;
        if (in_fire) begin
            r_rsp   <= n_rsp;
            r_rd_ok <= is_read && rd_in_range;
        end
    end

    // Result port; readout byte comes from the store's read register
    always_comb begin
        o_out.payload              = r_rsp;
        o_out.payload.payload_byte = r_rd_ok ? ram_rdata : 8'h00;
    end
    assign o_out.valid = r_out_valid;

    // Checks
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(FRAME_BYTES))
        else $error("write position beyond frame store");

    a_tail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cap |-> r_tail == 2'd0)
        else $error("tail progress while not capturing");

    a_readout_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.report_kind == KIND_READOUT |->
            o_out.payload.status == ST_OK && o_out.payload.payload_length == 8'h00)
        else $error("readout carries report fields");
endmodule
